// ===== sv/lpwp_pkg.sv =====
// Shared constants, state encoding and word record for the length-prefix packetizer.
`default_nettype none

package lpwp_pkg;

    // Fixed field widths
    localparam int BYTE_W             = 8;
    localparam int LEN_W              = 16;
    localparam int DATA_W             = 32;
    localparam int EMPTY_W            = 2;
    localparam int LANE_CALC_W        = 4;

    // Default packing width in bytes (legal range 2 to 4)
    localparam int BYTES_PER_WORD_DEF = 4;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'b001,
        PH_LEN_LO  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // One output word with its packet markers
    typedef struct packed {
        logic [DATA_W-1:0]  data_word;
        logic               start_of_packet;
        logic               end_of_packet;
        logic [EMPTY_W-1:0] empty_bytes;
    } t_word;

endpackage

`default_nettype wire

// ===== sv/lpwp_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the word output.
`default_nettype none

interface lpwp_byte_if
    import lpwp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpwp_word_if
    import lpwp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  data_word;
    logic               start_of_packet;
    logic               end_of_packet;
    logic [EMPTY_W-1:0] empty_bytes;

    modport source (output valid, output data_word, output start_of_packet,
                    output end_of_packet, output empty_bytes, input ready);
    modport sink   (input valid, input data_word, input start_of_packet,
                    input end_of_packet, input empty_bytes, output ready);
endinterface

`default_nettype wire

// ===== sv/lpwp_packer.sv =====
// Length parser and byte-to-word packer: parse state, partial word and result logic.
`default_nettype none

module lpwp_packer
    import lpwp_pkg::*;
#(
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_res_valid,
    output t_word                  o_res
);

    localparam int WORD_W = BYTE_W * BYTES_PER_WORD;
    localparam int LANE_W = $clog2(BYTES_PER_WORD);
    localparam logic [LANE_W:0]        LANE_COUNT = (LANE_W+1)'(BYTES_PER_WORD);
    localparam logic [LANE_W-1:0]      LANE_LAST  = LANE_W'(BYTES_PER_WORD - 1);
    localparam logic [LANE_CALC_W-1:0] LAST_CALC  = LANE_CALC_W'(BYTES_PER_WORD - 1);

    t_phase            r_phase,   n_phase;
    logic [BYTE_W-1:0] r_len_hi,  n_len_hi;
    logic [LEN_W-1:0]  r_rem,     n_rem;
    logic [LANE_W-1:0] r_lane,    n_lane;
    logic [WORD_W-1:0] r_partial, n_partial;
    logic              r_first,   n_first;

    logic [LANE_W-1:0]      lane_sel;
    logic [WORD_W-1:0]      word;
    logic [LEN_W-1:0]       rem_dec;
    logic [LEN_W-1:0]       len;
    logic                   last;
    logic                   full;
    logic [LANE_CALC_W-1:0] empty_calc;
    logic [DATA_W-1:0]      data_out;

    // Wrap an out-of-range lane back to zero
    assign lane_sel = ({1'b0, r_lane} >= LANE_COUNT) ? '0 : r_lane;

    // Drop the byte into its lane
    always_comb begin
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            word[BYTE_W*i +: BYTE_W] = (lane_sel == LANE_W'(i)) ? i_byte
                                                                : r_partial[BYTE_W*i +: BYTE_W];
        end
    end

    assign rem_dec    = r_rem - LEN_W'(1);
    assign last       = (rem_dec == '0);
    assign full       = (lane_sel == LANE_LAST);
    assign len        = {r_len_hi, i_byte};
    assign empty_calc = LAST_CALC - LANE_CALC_W'(lane_sel);

    // Fit the packed word onto the 32-bit data field
    generate
        if (WORD_W >= DATA_W) begin : g_trunc
            assign data_out = word[DATA_W-1:0];
        end else begin : g_pad
            assign data_out = {{(DATA_W-WORD_W){1'b0}}, word};
        end
    endgenerate

    // Advance the parser on each accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_len_hi    = r_len_hi;
        n_rem       = r_rem;
        n_lane      = r_lane;
        n_partial   = r_partial;
        n_first     = r_first;
        o_res_valid = 1'b0;
        o_res.data_word       = data_out;
        o_res.start_of_packet = r_first;
        o_res.end_of_packet   = last;
        o_res.empty_bytes     = last ? empty_calc[EMPTY_W-1:0] : '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_LEN_LO: begin
                    n_lane    = '0;
                    n_partial = '0;
                    n_first   = 1'b1;
                    n_rem     = len;
                    n_phase   = (len == '0) ? PH_LEN_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_rem = rem_dec;
                    if (!last && !full) begin
                        n_partial = word;
                        n_lane    = lane_sel + LANE_W'(1);
                    end else begin
                        o_res_valid = 1'b1;
                        n_partial   = '0;
                        n_lane      = '0;
                        n_first     = last;
                        if (last) begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                end
                default: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_HI;
            r_len_hi  <= '0;
            r_rem     <= '0;
            r_lane    <= '0;
            r_partial <= '0;
            r_first   <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_len_hi  <= n_len_hi;
            r_rem     <= n_rem;
            r_lane    <= n_lane;
            r_partial <= n_partial;
            r_first   <= n_first;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lpwp_skid.sv =====
// Two-entry output register with skid slot for finished words.
`default_nettype none

module lpwp_skid
    import lpwp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_word i_data,
    output logic       o_ready,
    output logic       o_valid,
    output t_word      o_data,
    input  wire logic  i_ready
);

    logic  r_main_valid, n_main_valid;
    logic  r_skid_valid, n_skid_valid;
    t_word r_main,       n_main;
    t_word r_skid,       n_skid;
    logic  main_free;

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;
    assign main_free = !r_main_valid || i_ready;

    // Refill the main slot from skid first, else from the new word; park the new word in skid while main is held
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (main_free) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_data;
                n_main_valid = i_valid;
            end
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== sv/length_prefix_to_word_packetizer_unit.sv =====
// Top level: length-prefixed byte stream in, packed packet words out.
//
//  Channel   Dir  Payload                                           Accepted when
//  i_byte    in   in_byte[7:0]                                      valid && ready
//  o_word    out  data_word[31:0] start_of_packet end_of_packet     valid && ready
//                 empty_bytes[1:0]
//
// One byte is taken per cycle while i_byte.ready is high; a completed word is registered
// into the output slots. Parse state is registered; its next value is combinational.
// Reset (synchronous, active low) returns the parser to expecting a length high byte.
// i_byte.ready drops only when both output slots hold words, so a stalled sink
// backs up two words before the input stops.
`default_nettype none

module length_prefix_to_word_packetizer_unit
    import lpwp_pkg::*;
#(
    parameter int BYTES_PER_WORD = BYTES_PER_WORD_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpwp_byte_if.sink   i_byte,
    lpwp_word_if.source o_word
);

    logic  accept;
    logic  skid_ready;
    logic  res_valid;
    t_word res;
    t_word out_word;

    assign i_byte.ready = skid_ready;
    assign accept       = i_byte.valid && skid_ready;

    lpwp_packer #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_byte.in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpwp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (skid_ready),
        .o_valid (o_word.valid),
        .o_data  (out_word),
        .i_ready (o_word.ready)
    );

    assign o_word.data_word       = out_word.data_word;
    assign o_word.start_of_packet = out_word.start_of_packet;
    assign o_word.end_of_packet   = out_word.end_of_packet;
    assign o_word.empty_bytes     = out_word.empty_bytes;

endmodule

`default_nettype wire

// ===== sv/lpwp_checker.sv =====
// Port-level checks for the packetizer, bound to the top level.
`default_nettype none

module lpwp_checker
    import lpwp_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    lpwp_byte_if.sink   i_byte,
    lpwp_word_if.source o_word
);

    logic r_expect_sop;
    logic out_acc;

    assign out_acc = o_word.valid && o_word.ready;

    // Track whether the next word must open a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_sop <= 1'b1;
        end else if (out_acc) begin
            r_expect_sop <= o_word.end_of_packet;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_word.valid)
        else $error("word valid right after reset");

    a_sop_follows_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_word.start_of_packet == r_expect_sop))
        else $error("start_of_packet does not follow end_of_packet");

    a_empty_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && (o_word.empty_bytes != '0)) |-> o_word.end_of_packet)
        else $error("empty_bytes set on a word that is not last");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && !o_word.ready) |=>
            (o_word.valid && $stable(o_word.data_word) &&
             $stable(o_word.end_of_packet) && $stable(o_word.empty_bytes)))
        else $error("stalled word changed");

    // Input backpressure only while a word is waiting at the output
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> o_word.valid)
        else $error("byte input stalled with no word waiting");

endmodule

bind length_prefix_to_word_packetizer_unit lpwp_checker u_lpwp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_byte  (i_byte),
    .o_word  (o_word)
);

`default_nettype wire

// ===== tb/sv/length_prefix_to_word_packetizer_unit_tb.sv =====
// Self-checking testbench for the length-prefix packetizer: framed byte stream in, checked words out.
`default_nettype none

module length_prefix_to_word_packetizer_unit_tb;
    import lpwp_pkg::*;

    localparam int          BPW       = BYTES_PER_WORD_DEF;
    localparam int unsigned LIMIT     = 1_000_000;
    localparam int unsigned RAND_BYTES = 220;

    // Expected-word tracker: follows the parser state and queues the words it should emit
    class word_scoreboard;
        t_phase      phase         = PH_LEN_HI;
        logic [7:0]  len_hi        = '0;
        logic [15:0] remaining     = '0;
        int unsigned lane          = 0;
        logic [63:0] partial       = '0;
        bit          first_pending = 1'b1;
        t_word       expected_words[$];
        int unsigned errors        = 0;

        // Advance the parser by one accepted byte and queue any word it completes
        function void note_byte(logic [7:0] b);
            logic [15:0] msg_len;
            int unsigned slot;
            logic [63:0] word;
            bit          is_last;
            bit          is_full;
            t_word       w;
            case (phase)
                PH_LEN_LO: begin
                    msg_len       = {len_hi, b};
                    lane          = 0;
                    partial       = '0;
                    first_pending = 1'b1;
                    remaining     = msg_len;
                    // a zero-length message emits nothing
                    phase         = (msg_len == 16'd0) ? PH_LEN_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    slot      = (lane >= BPW) ? 0 : lane;
                    word      = partial | (64'(b) << (8 * slot));
                    remaining = remaining - 16'd1;
                    is_last   = (remaining == 16'd0);
                    is_full   = (slot + 1 >= BPW);
                    if (!is_last && !is_full) begin
                        partial = word;
                        lane    = slot + 1;
                    end else begin
                        w.data_word       = word[DATA_W-1:0];
                        w.start_of_packet = first_pending;
                        w.end_of_packet   = is_last;
                        w.empty_bytes     = is_last ? EMPTY_W'(BPW - 1 - slot) : '0;
                        expected_words.push_back(w);
                        partial       = '0;
                        lane          = 0;
                        first_pending = is_last;
                        if (is_last) phase = PH_LEN_HI;
                    end
                end
                default: begin
                    len_hi = b;
                    phase  = PH_LEN_LO;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Match one accepted word against the oldest expected word
        function void check_word(t_word got);
            t_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual data=%h sop=%b eop=%b empty=%0d",
                         $time, got.data_word, got.start_of_packet, got.end_of_packet,
                         got.empty_bytes);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("data_word", want.data_word, got.data_word);
            compare_field("start_of_packet", 32'(want.start_of_packet), 32'(got.start_of_packet));
            compare_field("end_of_packet", 32'(want.end_of_packet), 32'(got.end_of_packet));
            compare_field("empty_bytes", 32'(want.empty_bytes), 32'(got.empty_bytes));
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n;
    lpwp_byte_if    byte_if ();
    lpwp_word_if    word_if ();
    word_scoreboard sb = new;
    bit             quiet_mode  = 1'b0;
    int unsigned    items_sent  = 0;
    int unsigned    cycle_count = 0;

    length_prefix_to_word_packetizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_word  (word_if)
    );

    always #4 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long; none at all in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte after a random gap and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        sb.note_byte(b);
        items_sent++;
    endtask

    // Send a length prefix and a random payload
    task automatic send_message(input logic [15:0] msg_len);
        send_byte(msg_len[15:8]);
        send_byte(msg_len[7:0]);
        for (int unsigned i = 0; i < msg_len; i++) send_byte(8'($urandom));
    endtask

    // Pause the input until every expected word has arrived
    task automatic drain_words();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Word side: check accepted words and drive ready with random stalls
    initial begin : word_sink
        int unsigned stall_left;
        int unsigned words_taken;
        bit          held;
        int          gap;
        t_word       got;
        stall_left  = 0;
        words_taken = 0;
        held        = 1'b0;
        word_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (word_if.valid && word_if.ready) begin
                got.data_word       = word_if.data_word;
                got.start_of_packet = word_if.start_of_packet;
                got.end_of_packet   = word_if.end_of_packet;
                got.empty_bytes     = word_if.empty_bytes;
                sb.check_word(got);
                words_taken++;
            end
            if (stall_left > 0) begin
                word_if.ready <= 1'b0;
                stall_left--;
            end else if (!held && words_taken >= 40) begin
                // hold off long enough for the block to fill up and stall its input
                held          = 1'b1;
                stall_left    = 299;
                word_if.ready <= 1'b0;
            end else begin
                gap = pick_gap();
                word_if.ready <= (gap == 0);
                if (gap > 0) stall_left = gap - 1;
            end
        end
    end

    // Byte side: reset, directed messages, random messages, a long message, then wrap up
    initial begin : stimulus
        int  r;
        bit  paused;
        logic [15:0] msg_len;
        paused = 1'b0;
        i_rst_n         <= 1'b0;
        byte_if.valid   <= 1'b0;
        byte_if.in_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero length, single byte, full word, two words, partial lanes
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h04);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A); send_byte(8'hA5);
        send_message(16'd6);
        send_message(16'd3);
        send_byte(8'h00); send_byte(8'h00);
        drain_words();

        // Random messages, mostly short, with one full drain halfway
        while (items_sent < RAND_BYTES) begin
            r = $urandom_range(0, 99);
            quiet_mode = ($urandom_range(0, 4) == 0);
            if (r < 15)      msg_len = 16'd0;
            else if (r < 80) msg_len = 16'($urandom_range(1, 12));
            else             msg_len = 16'($urandom_range(13, 40));
            send_message(msg_len);
            if (!paused && items_sent >= RAND_BYTES / 2) begin
                drain_words();
                paused = 1'b1;
            end
        end

        // A long message exercises the upper length bits; run it without idling
        quiet_mode = 1'b1;
        send_message(16'($urandom_range(256, 300)));
        quiet_mode = 1'b0;
        send_message(16'd7);

        byte_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== length_prefix_to_word_packetizer_unit.f =====
sv/lpwp_pkg.sv
sv/lpwp_ifs.sv
sv/lpwp_packer.sv
sv/lpwp_skid.sv
sv/length_prefix_to_word_packetizer_unit.sv
sv/lpwp_checker.sv
tb/sv/length_prefix_to_word_packetizer_unit_tb.sv
